// ===== rtl/core/sdc_pkg.sv =====
// Shared types and sizes for the stick distance constraint pipeline.
// No dependencies; used by stick_distance_constraint.
`default_nettype none
package sdc_pkg;
  localparam int unsigned CoordW = 32;        // coordinate width
  localparam int unsigned DeltaW = 33;        // |second - first|
  localparam int unsigned SqW = 66;           // sum of squares
  localparam int unsigned RootW = 34;         // floor square root
  localparam int unsigned RadW = 2 * RootW;   // padded radicand
  localparam int unsigned SqRemW = 36;        // square root remainder
  localparam int unsigned DiffW = 34;         // |rest - dist|
  localparam int unsigned DivW = 35;          // divisor (dist or 2*dist)
  localparam int unsigned ProdW = DeltaW + DiffW;
  localparam int unsigned QuotW = 35;         // quotient bits produced
  localparam int unsigned SqSteps = RootW;
  localparam int unsigned DvSteps = QuotW;

  // Word fields carried alongside the arithmetic
  typedef struct packed {
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] y0;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic                     fix0;
    logic                     fix1;
    logic                     zero;
    logic [CoordW-2:0]        rest;
    logic [DeltaW-1:0]        mx;
    logic [DeltaW-1:0]        my;
    logic                     sx;
    logic                     sy;
  } carry_t;
endpackage
`default_nettype wire

// ===== rtl/core/stick_distance_constraint.sv =====
// Stick distance constraint: one relaxation step for one stick per word.
// Throughput: one word per cycle while no finished word is stalled at the output.
// The pipeline advances as a whole unless a finished word is stalled at the output.
// Square root takes one root bit per stage (34 stages), each divider one quotient bit
// per stage (35 stages). Reset clears all valid bits; payload registers are not reset.
// Depends on sdc_pkg.
`default_nettype none
module stick_distance_constraint (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output      logic                        stall_o,
  input  wire logic signed [31:0]          first_x_i,
  input  wire logic signed [31:0]          first_y_i,
  input  wire logic signed [31:0]          second_x_i,
  input  wire logic signed [31:0]          second_y_i,
  input  wire logic                        first_fixed_i,
  input  wire logic                        second_fixed_i,
  input  wire logic [30:0]                 rest_length_i,
  output      logic                        valid_o,
  input  wire logic                        stall_i,
  output      logic signed [31:0]          new_first_x_o,
  output      logic signed [31:0]          new_first_y_o,
  output      logic signed [31:0]          new_second_x_o,
  output      logic signed [31:0]          new_second_y_o,
  output      logic                        zero_distance_o
);

  localparam int unsigned SqN = sdc_pkg::SqSteps;
  localparam int unsigned DvN = sdc_pkg::DvSteps;

  logic adv;
  assign adv     = !(valid_o && stall_i);
  assign stall_o = !adv;

  // Stage 1: deltas and magnitudes
  logic signed [sdc_pkg::DeltaW-1:0] dx, dy;
  sdc_pkg::carry_t c1_d, c1_q;
  logic v1_q;
  always_comb begin
    dx = {second_x_i[31], second_x_i} - {first_x_i[31], first_x_i};
    dy = {second_y_i[31], second_y_i} - {first_y_i[31], first_y_i};
    c1_d.x0   = first_x_i;
    c1_d.y0   = first_y_i;
    c1_d.x1   = second_x_i;
    c1_d.y1   = second_y_i;
    c1_d.fix0 = first_fixed_i;
    c1_d.fix1 = second_fixed_i;
    c1_d.rest = rest_length_i;
    c1_d.zero = (dx == '0) && (dy == '0);
    c1_d.sx   = dx[sdc_pkg::DeltaW-1];
    c1_d.sy   = dy[sdc_pkg::DeltaW-1];
    c1_d.mx   = dx[sdc_pkg::DeltaW-1] ? -dx : dx;
    c1_d.my   = dy[sdc_pkg::DeltaW-1] ? -dy : dy;
  end

  // Stage 2: squares
  sdc_pkg::carry_t c2_q;
  logic v2_q;
  logic [sdc_pkg::SqW-1:0] sqx_q, sqy_q;

  // Stage 3: sum of squares
  sdc_pkg::carry_t c3_q;
  logic v3_q;
  logic [sdc_pkg::SqW-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q  <= c1_d;
      c2_q  <= c1_q;
      sqx_q <= c1_q.mx * c1_q.mx;
      sqy_q <= c1_q.my * c1_q.my;
      c3_q  <= c2_q;
      sum_q <= sqx_q + sqy_q;
    end
  end

  // Square root: one root bit per stage
  sdc_pkg::carry_t                   sq_c_q    [SqN+1];
  logic                              sq_v_q    [SqN+1];
  logic [sdc_pkg::RadW-1:0]          sq_rad_q  [SqN+1];
  logic [sdc_pkg::RootW-1:0]         sq_root_q [SqN+1];
  logic [sdc_pkg::SqRemW-1:0]        sq_rem_q  [SqN+1];

  always_comb begin
    sq_c_q[0]    = c3_q;
    sq_v_q[0]    = v3_q;
    sq_rad_q[0]  = {{(sdc_pkg::RadW - sdc_pkg::SqW){1'b0}}, sum_q};
    sq_root_q[0] = '0;
    sq_rem_q[0]  = '0;
  end

  for (genvar k = 0; k < SqN; k++) begin : g_sqrt
    logic [sdc_pkg::SqRemW+1:0] t, trial;
    always_comb begin
      t     = {sq_rem_q[k], sq_rad_q[k][sdc_pkg::RadW-1 -: 2]};
      trial = {2'b00, sq_root_q[k], 2'b01};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_c_q[k+1]   <= sq_c_q[k];
        sq_rad_q[k+1] <= {sq_rad_q[k][sdc_pkg::RadW-3:0], 2'b00};
        if (t >= trial) begin
          sq_rem_q[k+1]  <= sdc_pkg::SqRemW'(t - trial);
          sq_root_q[k+1] <= {sq_root_q[k][sdc_pkg::RootW-2:0], 1'b1};
        end else begin
          sq_rem_q[k+1]  <= sdc_pkg::SqRemW'(t);
          sq_root_q[k+1] <= {sq_root_q[k][sdc_pkg::RootW-2:0], 1'b0};
        end
      end
    end
  end

  // Stage D: correction and divisor
  logic signed [sdc_pkg::DiffW:0] diff;
  assign diff = {{(sdc_pkg::DiffW + 1 - (sdc_pkg::CoordW - 1)){1'b0}}, sq_c_q[SqN].rest}
              - {1'b0, sq_root_q[SqN]};

  sdc_pkg::carry_t           cd_q;
  logic                      vd_q;
  logic [sdc_pkg::DiffW-1:0] md_q;
  logic                      sd_q;
  logic [sdc_pkg::DivW-1:0]  div_d_q;

  // Stage E: products
  sdc_pkg::carry_t           ce_q;
  logic                      ve_q;
  logic [sdc_pkg::ProdW-1:0] px_q, py_q;
  logic                      nx_q, ny_q;
  logic [sdc_pkg::DivW-1:0]  div_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (adv) begin
      vd_q <= sq_v_q[SqN];
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cd_q    <= sq_c_q[SqN];
      sd_q    <= diff[sdc_pkg::DiffW];
      md_q    <= sdc_pkg::DiffW'(diff[sdc_pkg::DiffW] ? -diff : diff);
      div_d_q <= (sq_c_q[SqN].fix0 || sq_c_q[SqN].fix1)
               ? {1'b0, sq_root_q[SqN]} : {sq_root_q[SqN], 1'b0};
      ce_q    <= cd_q;
      px_q    <= cd_q.mx * md_q;
      py_q    <= cd_q.my * md_q;
      nx_q    <= cd_q.sx ^ sd_q;
      ny_q    <= cd_q.sy ^ sd_q;
      div_e_q <= div_d_q;
    end
  end

  // Dividers: one quotient bit per stage, both lanes side by side
  localparam int unsigned NumLoW = sdc_pkg::QuotW;
  localparam int unsigned NumHiW = sdc_pkg::ProdW - NumLoW;

  sdc_pkg::carry_t           dv_c_q   [DvN+1];
  logic                      dv_v_q   [DvN+1];
  logic                      dv_nx_q  [DvN+1];
  logic                      dv_ny_q  [DvN+1];
  logic [sdc_pkg::DivW-1:0]  dv_d_q   [DvN+1];
  logic [NumLoW-1:0]         dv_nbx_q [DvN+1];
  logic [NumLoW-1:0]         dv_nby_q [DvN+1];
  logic [sdc_pkg::DivW-1:0]  dv_rx_q  [DvN+1];
  logic [sdc_pkg::DivW-1:0]  dv_ry_q  [DvN+1];
  logic [sdc_pkg::QuotW-1:0] dv_qx_q  [DvN+1];
  logic [sdc_pkg::QuotW-1:0] dv_qy_q  [DvN+1];

  always_comb begin
    dv_c_q[0]   = ce_q;
    dv_v_q[0]   = ve_q;
    dv_nx_q[0]  = nx_q;
    dv_ny_q[0]  = ny_q;
    dv_d_q[0]   = div_e_q;
    dv_nbx_q[0] = px_q[NumLoW-1:0];
    dv_nby_q[0] = py_q[NumLoW-1:0];
    dv_rx_q[0]  = {{(sdc_pkg::DivW - NumHiW){1'b0}}, px_q[sdc_pkg::ProdW-1:NumLoW]};
    dv_ry_q[0]  = {{(sdc_pkg::DivW - NumHiW){1'b0}}, py_q[sdc_pkg::ProdW-1:NumLoW]};
    dv_qx_q[0]  = '0;
    dv_qy_q[0]  = '0;
  end

  for (genvar j = 0; j < DvN; j++) begin : g_div
    logic [sdc_pkg::DivW:0] tx, ty, dd;
    always_comb begin
      tx = {dv_rx_q[j], dv_nbx_q[j][NumLoW-1]};
      ty = {dv_ry_q[j], dv_nby_q[j][NumLoW-1]};
      dd = {1'b0, dv_d_q[j]};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_c_q[j+1]   <= dv_c_q[j];
        dv_nx_q[j+1]  <= dv_nx_q[j];
        dv_ny_q[j+1]  <= dv_ny_q[j];
        dv_d_q[j+1]   <= dv_d_q[j];
        dv_nbx_q[j+1] <= {dv_nbx_q[j][NumLoW-2:0], 1'b0};
        dv_nby_q[j+1] <= {dv_nby_q[j][NumLoW-2:0], 1'b0};
        if (tx >= dd) begin
          dv_rx_q[j+1] <= sdc_pkg::DivW'(tx - dd);
          dv_qx_q[j+1] <= {dv_qx_q[j][sdc_pkg::QuotW-2:0], 1'b1};
        end else begin
          dv_rx_q[j+1] <= sdc_pkg::DivW'(tx);
          dv_qx_q[j+1] <= {dv_qx_q[j][sdc_pkg::QuotW-2:0], 1'b0};
        end
        if (ty >= dd) begin
          dv_ry_q[j+1] <= sdc_pkg::DivW'(ty - dd);
          dv_qy_q[j+1] <= {dv_qy_q[j][sdc_pkg::QuotW-2:0], 1'b1};
        end else begin
          dv_ry_q[j+1] <= sdc_pkg::DivW'(ty);
          dv_qy_q[j+1] <= {dv_qy_q[j][sdc_pkg::QuotW-2:0], 1'b0};
        end
      end
    end
  end

  // Stage F: round to nearest, ties away, and apply sign
  localparam int unsigned OffW = sdc_pkg::QuotW + 2;
  logic [sdc_pkg::DivW:0]    rx_w, ry_w, dvw;
  logic [sdc_pkg::QuotW:0]   qmx, qmy;
  sdc_pkg::carry_t           cf_q;
  logic                      vf_q;
  logic signed [OffW-1:0]    offx_q, offy_q;

  always_comb begin
    rx_w = {1'b0, dv_rx_q[DvN]};
    ry_w = {1'b0, dv_ry_q[DvN]};
    dvw  = {1'b0, dv_d_q[DvN]};
    qmx  = {1'b0, dv_qx_q[DvN]} + {{sdc_pkg::QuotW{1'b0}}, (rx_w >= dvw - rx_w)};
    qmy  = {1'b0, dv_qy_q[DvN]} + {{sdc_pkg::QuotW{1'b0}}, (ry_w >= dvw - ry_w)};
  end

  // Stage G: move free endpoints and saturate
  localparam int unsigned SumW = OffW + 1;
  logic signed [SumW-1:0] s_x0, s_y0, s_x1, s_y1;
  logic                   skip, mv0, mv1;

  function automatic logic signed [31:0] sat32(input logic signed [SumW-1:0] v);
    logic hi_ok;
    hi_ok = (v[SumW-1:31] == '0) || (v[SumW-1:31] == '1);
    if (hi_ok) begin
      sat32 = v[31:0];
    end else if (v[SumW-1]) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = 32'sh7fff_ffff;
    end
  endfunction

  always_comb begin
    skip = cf_q.zero || (cf_q.fix0 && cf_q.fix1);
    mv0  = !skip && !cf_q.fix0;
    mv1  = !skip && !cf_q.fix1;
    s_x0 = {{(SumW - 32){cf_q.x0[31]}}, cf_q.x0} - (mv0 ? {offx_q[OffW-1], offx_q} : '0);
    s_y0 = {{(SumW - 32){cf_q.y0[31]}}, cf_q.y0} - (mv0 ? {offy_q[OffW-1], offy_q} : '0);
    s_x1 = {{(SumW - 32){cf_q.x1[31]}}, cf_q.x1} + (mv1 ? {offx_q[OffW-1], offx_q} : '0);
    s_y1 = {{(SumW - 32){cf_q.y1[31]}}, cf_q.y1} + (mv1 ? {offy_q[OffW-1], offy_q} : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (adv) begin
      vf_q    <= dv_v_q[DvN];
      valid_o <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cf_q            <= dv_c_q[DvN];
      offx_q          <= dv_nx_q[DvN] ? -$signed({1'b0, qmx}) : $signed({1'b0, qmx});
      offy_q          <= dv_ny_q[DvN] ? -$signed({1'b0, qmy}) : $signed({1'b0, qmy});
      new_first_x_o   <= sat32(s_x0);
      new_first_y_o   <= sat32(s_y0);
      new_second_x_o  <= sat32(s_x1);
      new_second_y_o  <= sat32(s_y1);
      zero_distance_o <= cf_q.zero;
    end
  end

endmodule
`default_nettype wire
